// File: src/volume_gradient_stencil_core_defines.svh
// Assertion macros shared by the volume gradient stencil checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef VOLUME_GRADIENT_STENCIL_CORE_DEFINES_SVH
`define VOLUME_GRADIENT_STENCIL_CORE_DEFINES_SVH

// same-cycle implication
`define VGS_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("vgs check failed");

// next-cycle implication
`define VGS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vgs check failed");

`endif

// File: src/vgs_pkg.sv
// Shared constants and register codes for the volume gradient stencil.
// No dependencies.
package vgs_pkg;

    localparam int MAX_WIDTH_DEF   = 128;
    localparam int MAX_HEIGHT_DEF  = 128;
    localparam int MAX_DEPTH_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int SIZE_BITS     = 14;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 11;
    localparam int AXIS_BITS     = 2;
    localparam int WIDTH_BITS    = 8;
    localparam int HEIGHT_BITS   = 8;
    localparam int DEPTH_BITS    = 11;

    localparam logic [CFG_ADDR_BITS-1:0] REG_AXIS   = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MODE   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DEPTH  = 3'd4;

    localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;
    localparam logic MODE_CENTRAL = 1'b1;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RST  = 8'd128;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST = 8'd128;
    localparam logic [DEPTH_BITS-1:0]  DEPTH_RST  = 11'd1024;

    localparam logic [SIZE_BITS-1:0] SIZE_MIN = 14'd3;

endpackage

// File: src/volume_gradient_stencil_core.sv
// Streaming 3D gradient: takes one sample per cycle in raster order (x fastest) and returns one
// derivative for each interior voxel, passed through the stage B registers, the window cells and
// the output register once the sample one step beyond it in x, y and z is taken. Throughput is one
// sample per clock, set by the read-modify-write of the slice RAM (two previous slices per (y,x))
// and the row RAM (two previous rows per x), each one port pair per cycle. The output register
// stalls the whole pipe only while a result is held. Depends on vgs_pkg, vgs_ram and vgs_cell.
module volume_gradient_stencil_core #(
    parameter int MAX_WIDTH   = vgs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = vgs_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_DEPTH   = vgs_pkg::MAX_DEPTH_DEF,
    parameter int SAMPLE_BITS = vgs_pkg::SAMPLE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic                               cfg_we,
    input  logic [vgs_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [vgs_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // derivative, pos_x, pos_y, pos_z
    output logic [((SAMPLE_BITS+5+$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+$clog2(MAX_DEPTH)+7)/8)*8-1:0]
                                               m_tdata,
    output logic                               m_tlast
);

    localparam int SB = SAMPLE_BITS;
    localparam int DW = SAMPLE_BITS + 5;
    localparam int XB = $clog2(MAX_WIDTH);
    localparam int YB = $clog2(MAX_HEIGHT);
    localparam int ZB = $clog2(MAX_DEPTH);
    localparam int SW = vgs_pkg::SIZE_BITS;
    localparam int OB = ((DW + XB + YB + ZB + 7) / 8) * 8;
    localparam logic [SW-1:0] WMAX = SW'(MAX_WIDTH);
    localparam logic [SW-1:0] HMAX = SW'(MAX_HEIGHT);
    localparam logic [SW-1:0] DMAX = SW'(MAX_DEPTH);

    logic [vgs_pkg::AXIS_BITS-1:0]   axis_reg;
    logic                            mode_reg;
    logic [vgs_pkg::WIDTH_BITS-1:0]  width_reg;
    logic [vgs_pkg::HEIGHT_BITS-1:0] height_reg;
    logic [vgs_pkg::DEPTH_BITS-1:0]  depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg   <= vgs_pkg::AXIS_X;
            mode_reg   <= 1'b0;
            width_reg  <= vgs_pkg::WIDTH_RST;
            height_reg <= vgs_pkg::HEIGHT_RST;
            depth_reg  <= vgs_pkg::DEPTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                vgs_pkg::REG_AXIS:   axis_reg   <= cfg_wdata[vgs_pkg::AXIS_BITS-1:0];
                vgs_pkg::REG_MODE:   mode_reg   <= cfg_wdata[0];
                vgs_pkg::REG_WIDTH:  width_reg  <= cfg_wdata[vgs_pkg::WIDTH_BITS-1:0];
                vgs_pkg::REG_HEIGHT: height_reg <= cfg_wdata[vgs_pkg::HEIGHT_BITS-1:0];
                vgs_pkg::REG_DEPTH:  depth_reg  <= cfg_wdata[vgs_pkg::DEPTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic [SW-1:0] w_use, h_use, d_use;

    always_comb
    begin
        w_use = SW'(width_reg);
        h_use = SW'(height_reg);
        d_use = SW'(depth_reg);
        if (w_use < vgs_pkg::SIZE_MIN) w_use = vgs_pkg::SIZE_MIN;
        if (w_use > WMAX) w_use = WMAX;
        if (h_use < vgs_pkg::SIZE_MIN) h_use = vgs_pkg::SIZE_MIN;
        if (h_use > HMAX) h_use = HMAX;
        if (d_use < vgs_pkg::SIZE_MIN) d_use = vgs_pkg::SIZE_MIN;
        if (d_use > DMAX) d_use = DMAX;
    end

    // handshake and raster counters
    logic adv, accept;
    logic [XB-1:0] cx_reg, cx_next;
    logic [YB-1:0] cy_reg, cy_next;
    logic [ZB-1:0] cz_reg, cz_next;
    logic [SW-1:0] cx_w, cy_w, cz_w;
    logic          emit_a, last_a;

    assign adv      = !m_tvalid || m_tready;
    assign accept   = s_tvalid && adv;
    assign s_tready = adv;

    always_comb
    begin
        cx_w = SW'(cx_reg);
        cy_w = SW'(cy_reg);
        cz_w = SW'(cz_reg);
        emit_a = (cx_w >= SW'(2)) && (cy_w >= SW'(2)) && (cz_w >= SW'(2)) &&
                 (cx_w < w_use) && (cy_w < h_use) && (cz_w < d_use);
        last_a = (cx_w == w_use - SW'(1)) && (cy_w == h_use - SW'(1)) &&
                 (cz_w == d_use - SW'(1));
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        if (accept)
        begin
            if (cx_w + SW'(1) >= w_use)
            begin
                cx_next = '0;
                if (cy_w + SW'(1) >= h_use)
                begin
                    cy_next = '0;
                    if (cz_w + SW'(1) >= d_use)
                    begin
                        cz_next = '0;
                    end
                    else
                    begin
                        cz_next = cz_reg + ZB'(1);
                    end
                end
                else
                begin
                    cy_next = cy_reg + YB'(1);
                end
            end
            else
            begin
                cx_next = cx_reg + XB'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
        end
        else
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            cz_reg <= cz_next;
        end
    end

    // stage B: line RAM data returns
    logic          b_valid_reg, c_valid_reg;
    logic [SB-1:0] b_sample_reg;
    logic [XB-1:0] b_x_reg;
    logic [YB-1:0] b_y_reg;
    logic          b_emit_reg, b_last_reg, c_emit_reg, c_last_reg;
    logic [XB-1:0] b_px_reg, c_px_reg;
    logic [YB-1:0] b_py_reg, c_py_reg;
    logic [ZB-1:0] b_pz_reg, c_pz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= accept;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_sample_reg <= s_tdata[SB-1:0];
            b_x_reg      <= cx_reg;
            b_y_reg      <= cy_reg;
            b_emit_reg   <= emit_a;
            b_last_reg   <= last_a;
            b_px_reg     <= cx_reg - XB'(1);
            b_py_reg     <= cy_reg - YB'(1);
            b_pz_reg     <= cz_reg - ZB'(1);
            c_emit_reg   <= b_valid_reg && b_emit_reg;
            c_last_reg   <= b_last_reg;
            c_px_reg     <= b_px_reg;
            c_py_reg     <= b_py_reg;
            c_pz_reg     <= b_pz_reg;
        end
    end

    logic [2*SB-1:0] slice_rd;
    logic [6*SB-1:0] row_rd;
    logic            line_we;

    assign line_we = adv && b_valid_reg;

    vgs_ram #(
        .WIDTH(2*SB),
        .DEPTH(1 << (XB + YB))
    ) u_slice_ram (
        .clk  (clk),
        .we   (line_we),
        .waddr({b_y_reg, b_x_reg}),
        .wdata({slice_rd[SB-1:0], b_sample_reg}),
        .re   (adv),
        .raddr({cy_reg, cx_reg}),
        .rdata(slice_rd)
    );

    vgs_ram #(
        .WIDTH(6*SB),
        .DEPTH(1 << XB)
    ) u_row_ram (
        .clk  (clk),
        .we   (line_we),
        .waddr(b_x_reg),
        .wdata({row_rd[3*SB-1:0], slice_rd, b_sample_reg}),
        .re   (adv),
        .raddr(cx_reg),
        .rdata(row_rd)
    );

    // column: index dz*3+dy, dz 0 newest slice, dy 0 newest row
    logic [9*SB-1:0] col_b;

    always_comb
    begin
        for (int dz = 0; dz < 3; dz++)
        begin
            col_b[(dz*3)*SB +: SB] = (dz == 0) ? b_sample_reg : slice_rd[(dz-1)*SB +: SB];
            col_b[(dz*3+1)*SB +: SB] = row_rd[dz*SB +: SB];
            col_b[(dz*3+2)*SB +: SB] = row_rd[(3+dz)*SB +: SB];
        end
    end

    // window: cell 0 holds column x, cell 2 column x-2
    logic [9*SB-1:0]      cell_col [4];
    logic signed [DW-1:0] p_colsum [3];
    logic signed [DW-1:0] p_ydiff  [3];
    logic signed [DW-1:0] p_zdiff  [3];
    logic signed [DW-1:0] p_mid    [3];
    logic signed [DW-1:0] p_ycen   [3];
    logic signed [DW-1:0] p_zcen   [3];

    assign cell_col[0] = col_b;

    for (genvar i = 0; i < 3; i++)
    begin : g_cell
        vgs_cell #(
            .SAMPLE_BITS(SB)
        ) u_cell (
            .clk    (clk),
            .en     (line_we),
            .col_in (cell_col[i]),
            .col_out(cell_col[i+1]),
            .colsum (p_colsum[i]),
            .ydiff  (p_ydiff[i]),
            .zdiff  (p_zdiff[i]),
            .mid    (p_mid[i]),
            .ycen   (p_ycen[i]),
            .zcen   (p_zcen[i])
        );
    end

    logic signed [DW-1:0] deriv_c;

    always_comb
    begin
        case (axis_reg)
            vgs_pkg::AXIS_X:
            begin
                deriv_c = (mode_reg == vgs_pkg::MODE_CENTRAL) ? p_mid[0] - p_mid[2]
                                                               : p_colsum[0] - p_colsum[2];
            end
            vgs_pkg::AXIS_Y:
            begin
                deriv_c = (mode_reg == vgs_pkg::MODE_CENTRAL) ? p_ycen[1]
                                                               : p_ydiff[0] + p_ydiff[1] + p_ydiff[2];
            end
            default:
            begin
                deriv_c = (mode_reg == vgs_pkg::MODE_CENTRAL) ? p_zcen[1]
                                                               : p_zdiff[0] + p_zdiff[1] + p_zdiff[2];
            end
        endcase
    end

    // output register
    logic          m_valid_reg;
    logic [DW-1:0] m_deriv_reg;
    logic [XB-1:0] m_px_reg;
    logic [YB-1:0] m_py_reg;
    logic [ZB-1:0] m_pz_reg;
    logic          m_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= c_valid_reg && c_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_deriv_reg <= deriv_c;
            m_px_reg    <= c_px_reg;
            m_py_reg    <= c_py_reg;
            m_pz_reg    <= c_pz_reg;
            m_last_reg  <= c_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = OB'({m_pz_reg, m_py_reg, m_px_reg, m_deriv_reg});

endmodule

// File: src/vgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/vgs_cell.sv
// One column cell of the stencil window: holds a 3x3 (z by y) column and its partial sums.
// No dependencies; chained three deep by the top level.
module vgs_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [9*SAMPLE_BITS-1:0]   col_in,
    output logic [9*SAMPLE_BITS-1:0]   col_out,
    output logic signed [SAMPLE_BITS+4:0] colsum,
    output logic signed [SAMPLE_BITS+4:0] ydiff,
    output logic signed [SAMPLE_BITS+4:0] zdiff,
    output logic signed [SAMPLE_BITS+4:0] mid,
    output logic signed [SAMPLE_BITS+4:0] ycen,
    output logic signed [SAMPLE_BITS+4:0] zcen
);

    localparam int SB = SAMPLE_BITS;
    localparam int DW = SAMPLE_BITS + 5;

    logic [9*SB-1:0]       col_reg;
    logic signed [DW-1:0]  colsum_reg, ydiff_reg, zdiff_reg, mid_reg, ycen_reg, zcen_reg;
    logic signed [DW-1:0]  colsum_next, ydiff_next, zdiff_next, mid_next, ycen_next, zcen_next;
    logic signed [DW-1:0]  v [3][3];

    always_comb
    begin
        for (int dz = 0; dz < 3; dz++)
        begin
            for (int dy = 0; dy < 3; dy++)
            begin
                v[dz][dy] = DW'(signed'(col_in[(dz*3+dy)*SB +: SB]));
            end
        end
        colsum_next = '0;
        ydiff_next  = '0;
        zdiff_next  = '0;
        for (int k = 0; k < 3; k++)
        begin
            colsum_next = colsum_next + v[k][0] + v[k][1] + v[k][2];
            ydiff_next  = ydiff_next + v[k][0] - v[k][2];
            zdiff_next  = zdiff_next + v[0][k] - v[2][k];
        end
        mid_next  = v[1][1];
        ycen_next = v[1][0] - v[1][2];
        zcen_next = v[0][1] - v[2][1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg    <= col_in;
            colsum_reg <= colsum_next;
            ydiff_reg  <= ydiff_next;
            zdiff_reg  <= zdiff_next;
            mid_reg    <= mid_next;
            ycen_reg   <= ycen_next;
            zcen_reg   <= zcen_next;
        end
    end

    assign col_out = col_reg;
    assign colsum  = colsum_reg;
    assign ydiff   = ydiff_reg;
    assign zdiff   = zdiff_reg;
    assign mid     = mid_reg;
    assign ycen    = ycen_reg;
    assign zcen    = zcen_reg;

endmodule

// File: src/vgs_checker.sv
// Port-level checks for the volume gradient stencil, bound to the top level.
// Depends on vgs_pkg and volume_gradient_stencil_core_defines.svh.
`include "volume_gradient_stencil_core_defines.svh"

module vgs_checker #(
    parameter int MAX_WIDTH   = vgs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = vgs_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_DEPTH   = vgs_pkg::MAX_DEPTH_DEF,
    parameter int SAMPLE_BITS = vgs_pkg::SAMPLE_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    // derivative, pos_x, pos_y, pos_z
    input logic [((SAMPLE_BITS+5+$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+$clog2(MAX_DEPTH)+7)/8)*8-1:0]
                                             m_tdata,
    input logic                              m_tlast
);

    localparam int DW = SAMPLE_BITS + 5;
    localparam int XB = $clog2(MAX_WIDTH);

    `VGS_ASSERT_NOW(a_ready_follows_slot, 1'b1, s_tready == (!m_tvalid || m_tready))
    `VGS_ASSERT_NOW(a_pos_interior, m_tvalid, m_tdata[DW +: XB] != '0)
    `VGS_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
    `VGS_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

endmodule

bind volume_gradient_stencil_core vgs_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_DEPTH  (MAX_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
) u_vgs_checker (.*);

// File: dv/vgs_checker.sv
// Checker for the volume gradient stencil core: watches the register port and both streams,
// predicts each interior-voxel derivative from its own copy of the volume and compares.
// Depends on vgs_pkg.
`timescale 1ns / 100ps

module vgs_tb_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [vgs_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [vgs_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // sample
    input  logic [15:0]                       s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // derivative, pos_x, pos_y, pos_z
    input  logic [47:0]                       m_tdata,
    input  logic                              m_tlast,
    output int                                errors,
    output int                                pending
);
    import vgs_pkg::*;

    typedef struct packed {
        logic signed [20:0] deriv;
        logic [6:0]         px;
        logic [6:0]         py;
        logic [9:0]         pz;
        logic               fin;
    } grad_t;

    grad_t grad_q[$];

    logic signed [15:0] vox[3][128][128];
    logic [AXIS_BITS-1:0]   axis_r;
    logic                   mode_r;
    logic [WIDTH_BITS-1:0]  width_r;
    logic [HEIGHT_BITS-1:0] height_r;
    logic [DEPTH_BITS-1:0]  depth_r;
    int vx, vy, vz;

    function automatic int clamp_size(int v, int hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int vox_at(int x, int y, int z);
        return int'(vox[z % 3][y][x]);
    endfunction

    function automatic int gradient_at(int cx, int cy, int cz);
        int acc;
        acc = 0;
        for (int a = -1; a <= 1; a++)
        begin
            for (int b = -1; b <= 1; b++)
            begin
                if (mode_r == MODE_CENTRAL && (a != 0 || b != 0))
                    continue;
                if (axis_r == AXIS_X)
                    acc += vox_at(cx + 1, cy + a, cz + b) - vox_at(cx - 1, cy + a, cz + b);
                else if (axis_r == AXIS_Y)
                    acc += vox_at(cx + a, cy + 1, cz + b) - vox_at(cx + a, cy - 1, cz + b);
                else
                    acc += vox_at(cx + a, cy + b, cz + 1) - vox_at(cx + a, cy + b, cz - 1);
            end
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grad_t exp_g;
        grad_t got_g;
        int w, h, d;
        if (!rst_n)
        begin
            axis_r   <= AXIS_X;
            mode_r   <= 1'b0;
            width_r  <= WIDTH_RST;
            height_r <= HEIGHT_RST;
            depth_r  <= DEPTH_RST;
            vx = 0;
            vy = 0;
            vz = 0;
            errors  <= 0;
            pending <= 0;
            grad_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_g.deriv = m_tdata[20:0];
                got_g.px    = m_tdata[27:21];
                got_g.py    = m_tdata[34:28];
                got_g.pz    = m_tdata[44:35];
                got_g.fin   = m_tlast;
                if (grad_q.size() == 0)
                begin
                    $display("%0t unexpected result: deriv %0d at %0d/%0d/%0d last %0b",
                             $time, got_g.deriv, got_g.px, got_g.py, got_g.pz, got_g.fin);
                    errors <= errors + 1;
                end
                else
                begin
                    exp_g = grad_q.pop_front();
                    if (exp_g != got_g)
                    begin
                        $display("%0t mismatch: expected deriv %0d at %0d/%0d/%0d last %0b",
                                 $time, exp_g.deriv, exp_g.px, exp_g.py, exp_g.pz, exp_g.fin);
                        $display("%0t           actual deriv %0d at %0d/%0d/%0d last %0b",
                                 $time, got_g.deriv, got_g.px, got_g.py, got_g.pz, got_g.fin);
                        errors <= errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                w = clamp_size(int'(width_r), MAX_WIDTH_DEF);
                h = clamp_size(int'(height_r), MAX_HEIGHT_DEF);
                d = clamp_size(int'(depth_r), MAX_DEPTH_DEF);
                vox[vz % 3][vy][vx] = $signed(s_tdata);
                if (vx >= 2 && vy >= 2 && vz >= 2 && vx < w && vy < h && vz < d)
                begin
                    exp_g.deriv = 21'(gradient_at(vx - 1, vy - 1, vz - 1));
                    exp_g.px    = 7'(vx - 1);
                    exp_g.py    = 7'(vy - 1);
                    exp_g.pz    = 10'(vz - 1);
                    exp_g.fin   = (vx == w - 1) && (vy == h - 1) && (vz == d - 1);
                    grad_q.push_back(exp_g);
                end
                vx++;
                if (vx >= w)
                begin
                    vx = 0;
                    vy++;
                    if (vy >= h)
                    begin
                        vy = 0;
                        vz++;
                        if (vz >= d)
                            vz = 0;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_AXIS:   axis_r   <= cfg_wdata[AXIS_BITS-1:0];
                    REG_MODE:   mode_r   <= cfg_wdata[0];
                    REG_WIDTH:  width_r  <= cfg_wdata[WIDTH_BITS-1:0];
                    REG_HEIGHT: height_r <= cfg_wdata[HEIGHT_BITS-1:0];
                    REG_DEPTH:  depth_r  <= cfg_wdata[DEPTH_BITS-1:0];
                    default: ;
                endcase
            end
            pending <= grad_q.size();
        end
    end

endmodule

// File: dv/tb_top.sv
// Top of the volume gradient stencil testbench: drives registers and whole volumes of samples
// with random gaps and back-pressure, and gives the verdict. Depends on vgs_pkg, vgs_checker.
`timescale 1ns / 100ps

module tb_top;
    import vgs_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int ITEM_TARGET = 850;

    logic clk;
    logic rst_n;
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tlast;
    int errors;
    int pending;
    int cycles;
    int samples_sent;
    int volumes_sent;
    bit src_burst;
    bit sink_burst;

    volume_gradient_stencil_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    vgs_tb_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int clamp_size(int v, int hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // back-pressure: hold tready low for a drawn number of cycles before each result
    initial
    begin
        int n;
        m_tready = 1'b0;
        sink_burst = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 49) == 0)
                sink_burst = ~sink_burst;
            n = sink_burst ? 0 : $urandom_range(0, 19);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_BITS'(value);
        @(negedge clk);
    endtask

    task automatic send_sample(logic [15:0] value);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        samples_sent++;
    endtask

    function automatic logic [15:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    // pattern: 0 random, else extremes split on the coordinate along the derivative axis
    task automatic run_volume(int w_raw, int h_raw, int d_raw, int ax, int md, int pattern);
        int w, h, d, c;
        logic [15:0] v;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        write_reg(REG_AXIS, ax);
        write_reg(REG_MODE, md);
        write_reg(REG_WIDTH, w_raw);
        write_reg(REG_HEIGHT, h_raw);
        write_reg(REG_DEPTH, d_raw);
        cfg_we <= 1'b0;
        @(negedge clk);
        w = clamp_size(w_raw, MAX_WIDTH_DEF);
        h = clamp_size(h_raw, MAX_HEIGHT_DEF);
        d = clamp_size(d_raw, MAX_DEPTH_DEF);
        src_burst = ($urandom_range(0, 3) == 0);
        for (int z = 0; z < d; z++)
        begin
            for (int y = 0; y < h; y++)
            begin
                for (int x = 0; x < w; x++)
                begin
                    if (pattern == 0)
                        v = draw_sample();
                    else
                    begin
                        c = (ax == 0) ? x : ((ax == 1) ? y : z);
                        v = (c == 0) ? 16'h8000 : ((c == 2) ? 16'h7fff : 16'h0000);
                        if (pattern == 2)
                            v = (c == 0) ? 16'h7fff : ((c == 2) ? 16'h8000 : 16'h0000);
                    end
                    send_sample(v);
                end
            end
        end
        volumes_sent++;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        samples_sent = 0;
        volumes_sent = 0;
        src_burst = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_volume(3, 3, 3, 0, 0, 1);
        run_volume(3, 3, 3, 1, 0, 2);
        run_volume(3, 3, 3, 3, 1, 1);
        run_volume(0, 1, 2, 2, 1, 0);

        while (samples_sent < ITEM_TARGET)
            run_volume($urandom_range(3, 9), $urandom_range(3, 7), $urandom_range(3, 5),
                       $urandom_range(0, 3), $urandom_range(0, 1), 0);

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Streamed %0d volumes, %0d samples, all axes and both kernel modes,",
                 volumes_sent, samples_sent);
        $display("with extreme values, undersized sizes, random gaps and back-pressure.");
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
